/* rtl/core/mqtt_pkg.sv */
// shared types, constants and codes for the mqtt control packet parser
package mqtt_pkg;

	localparam int LenW = 28;

	// command queue depth
	localparam int QPtrW  = 2;
	localparam int QDepth = 1 << QPtrW;

	localparam logic [4:0] PH_HDR     = 5'd0;
	localparam logic [4:0] PH_LEN     = 5'd1;
	localparam logic [4:0] PH_SKIP    = 5'd2;
	localparam logic [4:0] PH_C_PNH   = 5'd3;
	localparam logic [4:0] PH_C_PNL   = 5'd4;
	localparam logic [4:0] PH_C_PNAME = 5'd5;
	localparam logic [4:0] PH_C_VER   = 5'd6;
	localparam logic [4:0] PH_C_SKIP3 = 5'd7;
	localparam logic [4:0] PH_C_PLEN  = 5'd8;
	localparam logic [4:0] PH_C_PROPS = 5'd9;
	localparam logic [4:0] PH_C_IDH   = 5'd10;
	localparam logic [4:0] PH_C_IDL   = 5'd11;
	localparam logic [4:0] PH_C_ID    = 5'd12;
	localparam logic [4:0] PH_C_TAIL  = 5'd13;
	localparam logic [4:0] PH_S_PIDH  = 5'd14;
	localparam logic [4:0] PH_S_PIDL  = 5'd15;
	localparam logic [4:0] PH_S_PLEN  = 5'd16;
	localparam logic [4:0] PH_S_PROPS = 5'd17;
	localparam logic [4:0] PH_S_TH    = 5'd18;
	localparam logic [4:0] PH_S_TL    = 5'd19;
	localparam logic [4:0] PH_S_TOPIC = 5'd20;
	localparam logic [4:0] PH_S_TAIL  = 5'd21;
	localparam logic [4:0] PH_P_TH    = 5'd22;
	localparam logic [4:0] PH_P_TL    = 5'd23;
	localparam logic [4:0] PH_P_TOPIC = 5'd24;
	localparam logic [4:0] PH_P_PLEN  = 5'd25;
	localparam logic [4:0] PH_P_PROPS = 5'd26;
	localparam logic [4:0] PH_P_PAY   = 5'd27;

	localparam logic [3:0] K_REPLY = 4'd0;
	localparam logic [3:0] K_CID   = 4'd1;
	localparam logic [3:0] K_STOP  = 4'd2;
	localparam logic [3:0] K_PTOP  = 4'd3;
	localparam logic [3:0] K_PAY   = 4'd4;
	localparam logic [3:0] K_DONE  = 4'd5;
	localparam logic [3:0] K_ERR   = 4'd6;
	localparam logic [3:0] K_DISC  = 4'd7;
	localparam logic [3:0] K_AUTO  = 4'd8;

	localparam logic [15:0] E_VER = 16'd0;
	localparam logic [15:0] E_LEN = 16'd1;
	localparam logic [15:0] E_TOP = 16'd2;
	localparam logic [15:0] E_PAY = 16'd3;

	localparam logic [3:0] T_CONNECT = 4'd1;
	localparam logic [3:0] T_PUBLISH = 4'd3;
	localparam logic [3:0] T_SUBSCR  = 4'd8;
	localparam logic [3:0] T_PINGREQ = 4'd12;
	localparam logic [3:0] T_DISC    = 4'd14;

	// trailing sequence that one input byte produces, expanded by the back end
	localparam logic [2:0] A_NONE    = 3'd0;
	localparam logic [2:0] A_DONE    = 3'd1;
	localparam logic [2:0] A_ERR     = 3'd2;
	localparam logic [2:0] A_CONNACK = 3'd3;
	localparam logic [2:0] A_SUBACK  = 3'd4;
	localparam logic [2:0] A_PING    = 3'd5;

	localparam logic [1:0] A_CFG_VER = 2'd0;
	localparam logic [1:0] A_CFG_TOP = 2'd1;
	localparam logic [1:0] A_CFG_PAY = 2'd2;

	typedef struct packed {
		logic [2:0]  act;
		logic        lead;
		logic [3:0]  kind;
		logic [15:0] value;
		logic [3:0]  ptype;
		logic [15:0] pid;
	} mqtt_cmd_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] value;
		logic        last;
	} mqtt_res_t;

endpackage

/* rtl/core/mqtt_front.sv */
// front end: parses the byte stream and issues at most one command per byte
module mqtt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [7:0]            in_byte,
	input  logic                  cmd_ready,
	output logic                  cmd_valid,
	output mqtt_pkg::mqtt_cmd_t   cmd,
	input  logic [7:0]            required_version,
	input  logic [15:0]           max_topic_length,
	input  logic [27:0]           max_payload_length
);
	import mqtt_pkg::*;

	logic [4:0]      phase_q, ph;
	logic [3:0]      pkind_q, pk;
	logic [LenW-1:0] left_q, bl;
	logic [LenW-1:0] acc_q, acc;
	logic [2:0]      dig_q, dig;
	logic [LenW-1:0] fc_q, fc;
	logic [15:0]     pid_q, pid;
	logic [15:0]     auto_q, au;
	logic            halt_q, hl;
	logic            fire;
	logic            lead;
	logic [2:0]      tail;
	logic [3:0]      okind;
	logic [15:0]     oval;
	logic            vdone, vover;
	logic [LenW-1:0] vsum;
	logic [4:0]      vshift;

	assign fire = in_valid && cmd_ready;

	always_comb begin
		vshift = 5'd7 * {3'd0, dig_q[1:0]};
		vsum = acc_q + (LenW'(in_byte[6:0]) << vshift);
		vdone = !in_byte[7];
		vover = in_byte[7] && (dig_q + 3'd1 >= 3'd4);
	end

	always_comb begin
		ph = phase_q; pk = pkind_q; bl = left_q; acc = acc_q; dig = dig_q;
		fc = fc_q; pid = pid_q; au = auto_q; hl = halt_q;
		lead = 1'b0; tail = A_NONE; okind = K_REPLY; oval = '0;
		if (!halt_q) begin
			if (phase_q == PH_HDR) begin
				pk = in_byte[7:4]; ph = PH_LEN; acc = '0; dig = '0;
			end else if (phase_q == PH_LEN) begin
				acc = vsum; dig = dig_q + 3'd1;
				if (vover) begin
					lead = 1'b1; okind = K_ERR; oval = E_LEN; hl = 1'b1; ph = PH_HDR;
				end else if (vdone) begin
					bl = vsum;
					case (pkind_q)
						T_CONNECT: ph = PH_C_PNH;
						T_PUBLISH: ph = PH_P_TH;
						T_SUBSCR:  ph = PH_S_PIDH;
						default:   ph = PH_SKIP;
					endcase
				end
			end else begin
				if (left_q != '0) bl = left_q - 1'b1;
				case (phase_q)
					PH_C_PNH: begin fc = LenW'({in_byte, 8'd0}); ph = PH_C_PNL; end
					PH_C_PNL: begin fc = fc_q | LenW'(in_byte); ph = PH_C_PNAME; end
					PH_C_PNAME, PH_C_PROPS, PH_S_PROPS, PH_P_PROPS: fc = fc_q - 1'b1;
					PH_C_VER: begin
						if (in_byte != required_version) begin
							lead = 1'b1; okind = K_ERR; oval = E_VER; hl = 1'b1;
							ph = PH_HDR;
						end else begin
							fc = LenW'(3); ph = PH_C_SKIP3;
						end
					end
					PH_C_SKIP3: begin
						fc = fc_q - 1'b1;
						if (fc == '0) begin ph = PH_C_PLEN; acc = '0; dig = '0; end
					end
					PH_C_PLEN, PH_S_PLEN, PH_P_PLEN: begin
						acc = vsum; dig = dig_q + 3'd1;
						if (vover) begin
							lead = 1'b1; okind = K_ERR; oval = E_LEN; hl = 1'b1;
							ph = PH_HDR;
						end else if (vdone) begin
							fc = vsum;
							ph = (phase_q == PH_C_PLEN) ? PH_C_PROPS :
								(phase_q == PH_S_PLEN) ? PH_S_PROPS : PH_P_PROPS;
						end
					end
					PH_C_IDH: begin fc = LenW'({in_byte, 8'd0}); ph = PH_C_IDL; end
					PH_C_IDL: begin
						fc = fc_q | LenW'(in_byte);
						if (fc == '0) begin
							lead = 1'b1; okind = K_AUTO; oval = auto_q;
							au = auto_q + 16'd1; ph = PH_C_TAIL;
						end else ph = PH_C_ID;
					end
					PH_C_ID: begin
						lead = 1'b1; okind = K_CID; oval = {8'd0, in_byte};
						fc = fc_q - 1'b1;
					end
					PH_S_PIDH: begin pid = {in_byte, 8'd0}; ph = PH_S_PIDL; end
					PH_S_PIDL: begin
						pid = pid_q | {8'd0, in_byte}; ph = PH_S_PLEN; acc = '0; dig = '0;
					end
					PH_S_TH, PH_P_TH: begin
						fc = LenW'({in_byte, 8'd0});
						ph = (phase_q == PH_S_TH) ? PH_S_TL : PH_P_TL;
					end
					PH_S_TL, PH_P_TL: begin
						fc = fc_q | LenW'(in_byte);
						if (fc > LenW'(max_topic_length)) begin
							lead = 1'b1; okind = K_ERR; oval = E_TOP; hl = 1'b1;
							ph = PH_HDR;
						end else ph = (phase_q == PH_S_TL) ? PH_S_TOPIC : PH_P_TOPIC;
					end
					PH_S_TOPIC: begin
						lead = 1'b1; okind = K_STOP; oval = {8'd0, in_byte};
						fc = fc_q - 1'b1;
					end
					PH_P_TOPIC: begin
						lead = 1'b1; okind = K_PTOP; oval = {8'd0, in_byte};
						fc = fc_q - 1'b1;
					end
					PH_P_PAY: begin lead = 1'b1; okind = K_PAY; oval = {8'd0, in_byte}; end
					default: ;
				endcase
				// settle phases whose count is already zero
				if (ph == PH_C_PNAME && fc == '0) ph = PH_C_VER;
				if (ph == PH_C_PROPS && fc == '0) ph = PH_C_IDH;
				if (ph == PH_C_ID && fc == '0) ph = PH_C_TAIL;
				if (ph == PH_S_PROPS && fc == '0) ph = PH_S_TH;
				if (ph == PH_S_TOPIC && fc == '0) ph = PH_S_TAIL;
				if (ph == PH_P_TOPIC && fc == '0) begin ph = PH_P_PLEN; acc = '0; dig = '0; end
				if (ph == PH_P_PROPS && fc == '0) begin
					if (bl > max_payload_length) begin
						lead = 1'b1; okind = K_ERR; oval = E_PAY; hl = 1'b1; ph = PH_HDR;
					end else ph = PH_P_PAY;
				end
			end
			// packet end; a field word of this byte may precede the trailing sequence
			if (!hl && ph >= PH_SKIP && bl == '0) begin
				case (ph)
					PH_C_TAIL: tail = A_CONNACK;
					PH_S_TAIL: tail = A_SUBACK;
					PH_P_PAY:  tail = A_DONE;
					PH_SKIP: begin
						if (pk == T_PINGREQ) tail = A_PING;
						else if (pk == T_DISC) begin
							lead = 1'b1; okind = K_DISC; oval = '0; hl = 1'b1;
						end else tail = A_DONE;
					end
					default: begin
						// body ended before the fields were complete
						tail = A_ERR; hl = 1'b1;
					end
				endcase
				ph = PH_HDR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR; pkind_q <= '0; left_q <= '0; acc_q <= '0; dig_q <= '0;
			fc_q <= '0; pid_q <= '0; auto_q <= 16'd1; halt_q <= 1'b0;
		end else if (fire) begin
			phase_q <= ph; pkind_q <= pk; left_q <= bl; acc_q <= acc; dig_q <= dig;
			fc_q <= fc; pid_q <= pid; auto_q <= au; halt_q <= hl;
		end
	end

	// bytes that give no word are not queued
	always_comb begin
		cmd_valid = fire && (lead || tail != A_NONE);
		cmd.act = tail;
		cmd.lead = lead;
		cmd.kind = okind;
		cmd.value = oval;
		cmd.ptype = pk;
		cmd.pid = pid;
	end
endmodule

/* rtl/core/mqtt_queue.sv */
// small command queue between the front end and the back end
module mqtt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  mqtt_pkg::mqtt_cmd_t wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output mqtt_pkg::mqtt_cmd_t rd_data
);
	import mqtt_pkg::*;

	mqtt_cmd_t        mem_q [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != (QPtrW+1)'(QDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
		end
	end
endmodule

/* rtl/core/mqtt_back.sv */
// back end: expands commands into result words
module mqtt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  mqtt_pkg::mqtt_cmd_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output mqtt_pkg::mqtt_res_t res
);
	import mqtt_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] tidx;
	logic [3:0] tcnt;
	logic [3:0] cnt;
	mqtt_res_t  cur;
	logic       any;
	logic       step;

	// number of words a command yields
	always_comb begin
		case (cmd.act)
			A_DONE, A_ERR: tcnt = 4'd1;
			A_CONNACK:     tcnt = 4'd6;
			A_SUBACK:      tcnt = 4'd7;
			A_PING:        tcnt = 4'd3;
			default:       tcnt = 4'd0;
		endcase
		cnt = tcnt + {3'd0, cmd.lead};
	end

	always_comb begin
		cur.kind = K_REPLY;
		cur.value = '0;
		tidx = idx_q - {2'd0, cmd.lead};
		if (cmd.lead && idx_q == 3'd0) begin
			cur.kind = cmd.kind; cur.value = cmd.value;
		end else begin
			case (cmd.act)
				A_DONE: begin cur.kind = K_DONE; cur.value = {12'd0, cmd.ptype}; end
				A_ERR: begin cur.kind = K_ERR; cur.value = E_LEN; end
				A_CONNACK: begin
					case (tidx)
						3'd0: cur.value = 16'h20;
						3'd1: cur.value = 16'h03;
						3'd5: begin cur.kind = K_DONE; cur.value = {12'd0, cmd.ptype}; end
						default: cur.value = '0;
					endcase
				end
				A_SUBACK: begin
					case (tidx)
						3'd0: cur.value = 16'h90;
						3'd1: cur.value = 16'h04;
						3'd2: cur.value = {8'd0, cmd.pid[15:8]};
						3'd3: cur.value = {8'd0, cmd.pid[7:0]};
						3'd6: begin cur.kind = K_DONE; cur.value = {12'd0, cmd.ptype}; end
						default: cur.value = '0;
					endcase
				end
				A_PING: begin
					case (tidx)
						3'd0: cur.value = 16'hD0;
						3'd2: begin cur.kind = K_DONE; cur.value = {12'd0, cmd.ptype}; end
						default: cur.value = '0;
					endcase
				end
				default: ;
			endcase
		end
		cur.last = (({1'b0, idx_q} + 4'd1) == cnt);
	end

	assign any = cmd_valid && (cnt != 4'd0);
	assign step = any && (!res_valid || res_ready);
	assign cmd_ready = (cmd_valid && cnt == 4'd0) || (step && cur.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; res_valid <= 1'b0;
		end else begin
			if (step) idx_q <= cur.last ? 3'd0 : idx_q + 3'd1;
			if (step) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res <= cur;
	end
endmodule

/* rtl/core/mqtt_control_packet_parser.sv */
// top level of the mqtt control packet parser
// a byte's first result word is registered in the command queue, then in the back-end output register
// throughput: one byte per cycle while each byte gives at most one word and the output is not stalled
// a completion burst (up to eight words) is emitted one word at a time by the back end, which waits on m_tready;
// a four-entry command queue absorbs it before the input stalls
// reset: asynchronous, clears parser state, queue and registers to defaults
module mqtt_control_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // stream_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_kind[3:0], out_value[19:4], zero fill
	output logic        m_tlast,   // out_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mqtt_pkg::*;

	logic [7:0]  ver_q;
	logic [15:0] top_q;
	logic [27:0] pay_q;
	logic        fcv, qrdy, qv, qrd;
	mqtt_cmd_t   fcmd, qcmd;
	mqtt_res_t   r;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q <= 8'd5; top_q <= 16'd127; pay_q <= 28'd1023;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				A_CFG_VER: ver_q <= pwdata[7:0];
				A_CFG_TOP: top_q <= pwdata[15:0];
				A_CFG_PAY: pay_q <= pwdata[27:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			A_CFG_VER: prdata = {24'd0, ver_q};
			A_CFG_TOP: prdata = {16'd0, top_q};
			A_CFG_PAY: prdata = {4'd0, pay_q};
			default:   prdata = '0;
		endcase
	end

	assign s_tready = qrdy;

	mqtt_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_byte(s_tdata), .cmd_ready(qrdy),
		.cmd_valid(fcv), .cmd(fcmd), .required_version(ver_q),
		.max_topic_length(top_q), .max_payload_length(pay_q)
	);

	mqtt_queue u_queue (
		.clk, .arst_n, .wr_valid(fcv), .wr_ready(qrdy), .wr_data(fcmd),
		.rd_valid(qv), .rd_ready(qrd), .rd_data(qcmd)
	);

	mqtt_back u_back (
		.clk, .arst_n, .cmd_valid(qv), .cmd_ready(qrd), .cmd(qcmd),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(r)
	);

	assign m_tdata = {4'd0, r.value, r.kind};
	assign m_tlast = r.last;
endmodule

/* rtl/core/mqtt_checker.sv */
// port-level checker for the mqtt control packet parser
module mqtt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word dropped while stalled");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= 4'd8)
		else $error("bad result kind");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:20] == 4'd0)
		else $error("fill bits set");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind mqtt_control_packet_parser mqtt_checker u_chk (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata, .m_tlast, .pready
);
